// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files of this project.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, masked while reset is high.
`define MRSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the rising clock edge that also runs through reset.
`define MRSP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mrsp_pkg.sv -----
// Shared types and constants of the MIDI running status parser.
// No dependencies; imported by every module of the block.
package mrsp_pkg;

   // message kind codes
   localparam logic [2:0] KIND_NOTE_OFF   = 3'd0;
   localparam logic [2:0] KIND_NOTE_ON    = 3'd1;
   localparam logic [2:0] KIND_SOUND_OFF  = 3'd2;
   localparam logic [2:0] KIND_CHAN_RESET = 3'd3;
   localparam logic [2:0] KIND_NOTES_OFF  = 3'd4;
   localparam logic [2:0] KIND_UNKNOWN    = 3'd5;
   localparam logic [2:0] KIND_STOP       = 3'd6;
   localparam logic [2:0] KIND_RESET      = 3'd7;

   // upper nibbles of channel status bytes
   localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
   localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
   localparam logic [3:0] STAT_MODE     = 4'hB;
   localparam logic [3:0] STAT_SYSTEM   = 4'hF;

   localparam logic [7:0] RUN_STATUS_RESET = 8'hFF;
   localparam logic [7:0] BYTE_STOP        = 8'hFC;
   localparam logic [7:0] BYTE_RESET       = 8'hFF;

   // channel mode controller numbers
   localparam logic [6:0] CTRL_SOUND_OFF    = 7'd120;
   localparam logic [6:0] CTRL_CHAN_RESET   = 7'd121;
   localparam logic [6:0] CTRL_NOTES_OFF_LO = 7'd123;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] channel;
      logic [6:0] pitch;
      logic [7:0] velocity;
   } mrsp_result_type;

   // one decoded result headed for the output buffer
   typedef struct packed {
      logic            push;
      mrsp_result_type data;
   } mrsp_push_type;

endpackage

// ----- hdl/mrsp_decode.sv -----
// Byte decoder: running status, held first data byte, per-byte decode.
// Depends on mrsp_pkg.
module mrsp_decode import mrsp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    midi_byte,
   output mrsp_push_type result
);

   logic [7:0] run_status_ff, run_status_in;
   logic       have_first_ff, have_first_in;
   logic [6:0] first_data_ff, first_data_in;
   logic       pair_status;

   assign pair_status = (run_status_ff[7:4] == STAT_NOTE_OFF) ||
                        (run_status_ff[7:4] == STAT_NOTE_ON)  ||
                        (run_status_ff[7:4] == STAT_MODE);

   always_comb begin
      run_status_in = run_status_ff;
      have_first_in = have_first_ff;
      first_data_in = first_data_ff;
      result        = '0;
      result.data.kind = KIND_UNKNOWN;

      if (have_first_ff) begin
         // second byte of a pair, taken whatever its value
         have_first_in        = 1'b0;
         result.data.channel  = run_status_ff[3:0];
         result.data.pitch    = first_data_ff;
         result.data.velocity = midi_byte;
         result.push          = 1'b1;
         if (run_status_ff[7:4] == STAT_NOTE_OFF) begin
            result.data.kind = KIND_NOTE_OFF;
         end else if (run_status_ff[7:4] == STAT_NOTE_ON) begin
            result.data.kind = KIND_NOTE_ON;
         end else if (first_data_ff == CTRL_SOUND_OFF && midi_byte == 8'd0) begin
            result.data.kind = KIND_SOUND_OFF;
         end else if (first_data_ff == CTRL_CHAN_RESET) begin
            result.data.kind = KIND_CHAN_RESET;
         end else if (first_data_ff >= CTRL_NOTES_OFF_LO) begin
            result.data.kind = KIND_NOTES_OFF;
         end else begin
            result.push = 1'b0;
         end
      end else if (!midi_byte[7]) begin
         if (pair_status) begin
            first_data_in = midi_byte[6:0];
            have_first_in = 1'b1;
         end else begin
            result.push = 1'b1;
         end
      end else if (midi_byte[7:4] != STAT_SYSTEM) begin
         run_status_in = midi_byte;
      end else if (!midi_byte[3]) begin
         // system common
         run_status_in = midi_byte;
         result.push   = 1'b1;
      end else begin
         // realtime
         result.push = 1'b1;
         if (midi_byte == BYTE_STOP) begin
            result.data.kind = KIND_STOP;
         end else if (midi_byte == BYTE_RESET) begin
            result.data.kind = KIND_RESET;
         end
      end

      if (!accept) begin
         run_status_in = run_status_ff;
         have_first_in = have_first_ff;
         first_data_in = first_data_ff;
         result.push   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_status_ff <= RUN_STATUS_RESET;
         have_first_ff <= 1'b0;
      end else begin
         run_status_ff <= run_status_in;
         have_first_ff <= have_first_in;
      end
      first_data_ff <= first_data_in;
   end

endmodule

// ----- hdl/mrsp_out_buf.sv -----
// Two-entry output register with skid stage for decoded results.
// Depends on mrsp_pkg.
module mrsp_out_buf import mrsp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  mrsp_push_type   in_push,
   output logic            in_ready,
   output logic            out_valid,
   input  logic            out_ready,
   output mrsp_result_type out_data
);

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   mrsp_result_type out_data_ff, out_data_in;
   mrsp_result_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         // head is free this cycle
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_data_in  = in_push.data;
            skid_valid_in = in_push.push;
         end else begin
            out_data_in  = in_push.data;
            out_valid_in = in_push.push;
         end
      end else if (in_push.push) begin
         skid_data_in  = in_push.data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- hdl/midi_running_status_parser.sv -----
// MIDI running status parser, top level: byte request in, message out.
// Depends on mrsp_pkg, mrsp_decode and mrsp_out_buf.
//
// Takes one received MIDI byte per request and gives zero or one decoded
// message per byte. A new byte can be accepted every clock cycle while
// req_ready is high; rsp_ is driven from a register. The output side holds
// up to two messages (output register plus skid stage), and req_ready
// drops only while both are full, so a stalled consumer costs at most the
// cycles it stalls. Status 0x80-0xEF sets the running status silently;
// data bytes under note off, note on or channel mode status are paired and
// the byte after the first one always completes the pair, even a status or
// realtime byte. Unknown, stop and reset messages carry zero in channel,
// pitch and velocity. Mode pairs with a controller other than sound off,
// channel reset or notes off produce nothing.
module midi_running_status_parser import mrsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // byte request
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_midi_byte,
   // decoded message
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [3:0] rsp_channel,
   output logic [6:0] rsp_pitch,
   output logic [7:0] rsp_velocity
);

   logic            req_accept;
   mrsp_push_type   dec_result;
   mrsp_result_type rsp_data;

   // request accepted when both sides agree
   assign req_accept = req_valid && req_ready;

   // running status and pair tracking; decode is pure logic on the byte
   mrsp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .midi_byte (req_midi_byte),
      .result    (dec_result)
   );

   // result register plus skid stage keeps ready registered
   mrsp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_push   (dec_result),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_kind     = rsp_data.kind;
   assign rsp_channel  = rsp_data.channel;
   assign rsp_pitch    = rsp_data.pitch;
   assign rsp_velocity = rsp_data.velocity;

endmodule

// ----- hdl/mrsp_checker.sv -----
// Port-level checks for the MIDI running status parser, bound to the top.
// Depends on mrsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrsp_checker import mrsp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [3:0] rsp_channel,
   input logic [6:0] rsp_pitch,
   input logic [7:0] rsp_velocity
);

   // a stalled message holds
   `MRSP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_kind, rsp_channel, rsp_pitch, rsp_velocity}), "rsp changed while stalled")

   // backpressure on requests only when a message is waiting
   `MRSP_ASSERT(a_ready_only_full, clock, reset, !req_ready |-> rsp_valid, "req_ready low with empty output")

   // non-channel messages carry zero fields
   `MRSP_ASSERT(a_zero_fields, clock, reset, rsp_valid && (rsp_kind == KIND_UNKNOWN || rsp_kind == KIND_STOP || rsp_kind == KIND_RESET) |-> rsp_channel == 4'd0 && rsp_pitch == 7'd0 && rsp_velocity == 8'd0, "nonzero fields on system message")

   // sound off only from controller 120 with value zero
   `MRSP_ASSERT(a_sound_off, clock, reset, rsp_valid && rsp_kind == KIND_SOUND_OFF |-> rsp_pitch == CTRL_SOUND_OFF && rsp_velocity == 8'd0, "bad sound off fields")

   // reset empties the output side
   `MRSP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "output not empty after reset")

endmodule

bind midi_running_status_parser mrsp_checker u_mrsp_checker (.*);
